// ----- rtl/asc_pkg.sv -----
// Shared types and constants for the alternating signal coordinator.
package asc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [TimeW-1:0] ClearanceRst = 32'd15000;
    localparam logic [TimeW-1:0] AckTimeoutRst = 32'd9000;
    localparam logic [TimeW-1:0] HeartbeatRst = 32'd2000;
    localparam logic [TimeW-1:0] LinkLossRst = 32'd9000;
    localparam logic [TimeW-1:0] LinkActiveRst = 32'd5000;

    localparam logic [CfgIdxW-1:0] CfgClearance = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgAckTimeout = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgHeartbeat = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgLinkLoss = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgLinkActive = 3'd4;

    localparam logic [2:0] CmdUpdate = 3'd0;
    localparam logic [2:0] CmdChange = 3'd1;
    localparam logic [2:0] CmdRestart = 3'd2;
    localparam logic [2:0] CmdFault = 3'd3;
    localparam logic [2:0] CmdAllRed = 3'd4;

    localparam logic [2:0] MsgPing = 3'd1;
    localparam logic [2:0] MsgPong = 3'd2;
    localparam logic [2:0] MsgAckGreen = 3'd3;
    localparam logic [2:0] MsgAckRed = 3'd4;

    localparam logic [1:0] ColRed = 2'd0;
    localparam logic [1:0] ColGreen = 2'd2;
    localparam logic [1:0] ColFault = 2'd3;

    localparam logic [1:0] OrdNone = 2'd0;
    localparam logic [1:0] OrdGreen = 2'd1;
    localparam logic [1:0] OrdRed = 2'd2;

    localparam logic [1:0] ActNone = 2'd0;
    localparam logic [1:0] ActRed = 2'd1;
    localparam logic [1:0] ActGreen = 2'd2;
    localparam logic [1:0] ActFault = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_INIT_WAIT = 4'd1,
        PH_M_TO_RED = 4'd2,
        PH_WAIT_AFTER_M = 4'd3,
        PH_ACK_GREEN = 4'd4,
        PH_ACK_RED = 4'd5,
        PH_WAIT_AFTER_S = 4'd6,
        PH_M_TO_GREEN = 4'd7,
        PH_FAULT = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        OWN_NONE = 2'd0,
        OWN_MASTER = 2'd1,
        OWN_SLAVE = 2'd2
    } t_owner;

    typedef struct packed {
        logic [TimeW-1:0] clearance_ms;
        logic [TimeW-1:0] ack_timeout_ms;
        logic [TimeW-1:0] heartbeat_ms;
        logic [TimeW-1:0] link_loss_ms;
        logic [TimeW-1:0] link_active_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0] command;
        logic [TimeW-1:0] now_ms;
        logic [2:0] rx_message;
        logic local_stable;
        logic [1:0] local_color;
    } t_item;

    typedef struct packed {
        logic send_pong;
        logic send_ping;
        logic [1:0] send_order;
        logic [1:0] light_action;
        logic ready_idle;
        logic comm_lost;
        logic link_ok;
        logic comm_active;
    } t_result;

endpackage

// ----- rtl/alternating_signal_coordinator_top.sv -----
// Path: an accepted item passes the input register, then the result register, before
// o_out_valid rises. Throughput: one item per cycle unless the output stalls; the
// coordinator state updates in a single pass per item. While a finished result waits,
// the input register takes at most one more item, then stalls.
// Reset is synchronous and active low: it empties both registers, returns the coordinator
// to idle with no green owner and all times unset, and restores the default timing values.
module alternating_signal_coordinator_top import asc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [TimeW-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [TimeW-1:0]   i_now_ms,
    input  logic [2:0]         i_rx_message,
    input  logic               i_local_stable,
    input  logic [1:0]         i_local_color,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_send_pong,
    output logic               o_send_ping,
    output logic [1:0]         o_send_order,
    output logic [1:0]         o_light_action,
    output logic               o_ready_idle,
    output logic               o_comm_lost,
    output logic               o_link_ok,
    output logic               o_comm_active
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    fire;
    logic    out_free;
    t_result step_result;
    t_result r_result;
    logic    r_out_valid;

    assign in_item.command      = i_command;
    assign in_item.now_ms       = i_now_ms;
    assign in_item.rx_message   = i_rx_message;
    assign in_item.local_stable = i_local_stable;
    assign in_item.local_color  = i_local_color;

    assign out_free = !r_out_valid || i_out_ready;
    assign fire     = stage_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clearance_ms   <= ClearanceRst;
            r_cfg.ack_timeout_ms <= AckTimeoutRst;
            r_cfg.heartbeat_ms   <= HeartbeatRst;
            r_cfg.link_loss_ms   <= LinkLossRst;
            r_cfg.link_active_ms <= LinkActiveRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgClearance:  r_cfg.clearance_ms   <= i_cfg_data;
                CfgAckTimeout: r_cfg.ack_timeout_ms <= i_cfg_data;
                CfgHeartbeat:  r_cfg.heartbeat_ms   <= i_cfg_data;
                CfgLinkLoss:   r_cfg.link_loss_ms   <= i_cfg_data;
                CfgLinkActive: r_cfg.link_active_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    asc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (fire),
        .o_item  (stage_item)
    );

    asc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_pong    = r_result.send_pong;
    assign o_send_ping    = r_result.send_ping;
    assign o_send_order   = r_result.send_order;
    assign o_light_action = r_result.light_action;
    assign o_ready_idle   = r_result.ready_idle;
    assign o_comm_lost    = r_result.comm_lost;
    assign o_link_ok      = r_result.link_ok;
    assign o_comm_active  = r_result.comm_active;

endmodule

// ----- rtl/asc_in_reg.sv -----
// Input register stage that captures one item per transfer.
module asc_in_reg import asc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- rtl/asc_step.sv -----
// Coordinator state and the single-pass step logic for one item.
module asc_step import asc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase r_phase, n_phase;
    t_owner r_owner, n_owner;
    logic   r_hs, n_hs;
    logic [TimeW-1:0] r_last_ping, n_last_ping;
    logic [TimeW-1:0] r_last_pong, n_last_pong;
    logic [TimeW-1:0] r_ack_start, n_ack_start;
    logic [TimeW-1:0] r_clr_start, n_clr_start;
    logic [TimeW-1:0] r_loss_start, n_loss_start;

    logic [TimeW-1:0] now;
    logic is_ping;
    logic is_pong;
    logic hs_a;
    logic [TimeW-1:0] ping_a;
    logic hb_due;
    logic hb_loss;
    logic hb_recover;
    t_phase phase_mid;
    t_owner owner_mid;
    logic clr_done;
    logic ack_late;

    assign now       = i_item.now_ms;
    assign is_ping   = (i_item.rx_message == MsgPing);
    assign is_pong   = (i_item.rx_message == MsgPong);
    assign hs_a      = r_hs || is_pong;
    assign ping_a    = is_pong ? now : r_last_ping;
    assign hb_due    = (now - ping_a) > i_cfg.heartbeat_ms;
    assign hb_loss   = hb_due && !hs_a && (r_loss_start != '0)
                       && ((now - r_loss_start) > i_cfg.link_loss_ms);
    assign hb_recover = hb_due && hs_a && (r_phase == PH_FAULT);
    assign clr_done  = (now - r_clr_start) >= i_cfg.clearance_ms;
    assign ack_late  = (now - r_ack_start) > i_cfg.ack_timeout_ms;

    always_comb begin
        phase_mid = r_phase;
        owner_mid = r_owner;
        if (hb_loss) begin
            phase_mid = PH_FAULT;
        end else if (hb_recover) begin
            phase_mid = PH_IDLE;
            owner_mid = OWN_NONE;
        end
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_owner      = r_owner;
        n_hs         = r_hs;
        n_last_ping  = r_last_ping;
        n_last_pong  = r_last_pong;
        n_ack_start  = r_ack_start;
        n_clr_start  = r_clr_start;
        n_loss_start = r_loss_start;
        case (i_item.command)
            CmdUpdate: begin
                n_hs        = hs_a;
                n_last_ping = ping_a;
                if (is_pong) begin
                    n_last_pong = now;
                end
                if (hb_due) begin
                    n_last_ping = now;
                    if (!hs_a) begin
                        if (r_loss_start == '0) begin
                            n_loss_start = now;
                        end
                    end else begin
                        n_hs         = 1'b0;
                        n_loss_start = '0;
                    end
                end
                n_phase = phase_mid;
                n_owner = owner_mid;
                case (phase_mid)
                    PH_INIT_WAIT, PH_WAIT_AFTER_M: begin
                        if (clr_done) begin
                            n_ack_start = now;
                            n_phase     = PH_ACK_GREEN;
                        end
                    end
                    PH_M_TO_RED: begin
                        if (i_item.local_stable && i_item.local_color == ColRed) begin
                            n_clr_start = now;
                            n_phase     = PH_WAIT_AFTER_M;
                        end
                    end
                    PH_ACK_GREEN: begin
                        if (i_item.rx_message == MsgAckGreen) begin
                            n_owner = OWN_SLAVE;
                            n_phase = PH_IDLE;
                        end else if (ack_late) begin
                            n_phase = PH_FAULT;
                        end
                    end
                    PH_ACK_RED: begin
                        if (i_item.rx_message == MsgAckRed) begin
                            n_clr_start = now;
                            n_phase     = PH_WAIT_AFTER_S;
                        end else if (ack_late) begin
                            n_phase = PH_FAULT;
                        end
                    end
                    PH_WAIT_AFTER_S: begin
                        if (clr_done) begin
                            n_phase = PH_M_TO_GREEN;
                        end
                    end
                    PH_M_TO_GREEN: begin
                        if (i_item.local_stable && i_item.local_color == ColGreen) begin
                            n_owner = OWN_MASTER;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CmdChange: begin
                if (r_phase == PH_IDLE) begin
                    case (r_owner)
                        OWN_NONE: begin
                            n_clr_start = now;
                            n_phase     = PH_INIT_WAIT;
                        end
                        OWN_MASTER: begin
                            n_phase = PH_M_TO_RED;
                        end
                        OWN_SLAVE: begin
                            n_ack_start = now;
                            n_phase     = PH_ACK_RED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CmdRestart: begin
                n_hs        = 1'b0;
                n_phase     = PH_IDLE;
                n_owner     = OWN_NONE;
                n_last_ping = '0;
            end
            CmdFault: begin
                n_phase = PH_FAULT;
            end
            CmdAllRed: begin
                n_phase = PH_IDLE;
                n_owner = OWN_NONE;
            end
            default: begin
            end
        endcase
    end

    // Result fields.
    always_comb begin
        o_result = '0;
        case (i_item.command)
            CmdUpdate: begin
                o_result.send_pong = is_ping;
                o_result.send_ping = hb_due;
                if (hb_recover) begin
                    o_result.light_action = ActRed;
                end
                case (phase_mid)
                    PH_INIT_WAIT, PH_WAIT_AFTER_M: begin
                        if (clr_done) begin
                            o_result.send_order = OrdGreen;
                        end
                    end
                    PH_WAIT_AFTER_S: begin
                        if (clr_done) begin
                            o_result.light_action = ActGreen;
                        end
                    end
                    PH_FAULT: begin
                        if (i_item.local_color != ColFault) begin
                            o_result.light_action = ActFault;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CmdChange: begin
                if (r_phase == PH_IDLE && r_owner == OWN_MASTER) begin
                    o_result.light_action = ActRed;
                end
                if (r_phase == PH_IDLE && r_owner == OWN_SLAVE) begin
                    o_result.send_order = OrdRed;
                end
            end
            CmdFault: begin
                if (i_item.local_color != ColFault) begin
                    o_result.light_action = ActFault;
                end
            end
            CmdAllRed: begin
                o_result.send_order   = OrdRed;
                o_result.light_action = ActRed;
            end
            default: begin
            end
        endcase
        o_result.ready_idle  = (n_phase == PH_IDLE);
        o_result.comm_lost   = (n_phase == PH_FAULT);
        o_result.link_ok     = n_hs;
        o_result.comm_active = (n_last_pong != '0)
                               && ((now - n_last_pong) < i_cfg.link_active_ms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_owner      <= OWN_NONE;
            r_hs         <= 1'b0;
            r_last_ping  <= '0;
            r_last_pong  <= '0;
            r_ack_start  <= '0;
            r_clr_start  <= '0;
            r_loss_start <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_owner      <= n_owner;
            r_hs         <= n_hs;
            r_last_ping  <= n_last_ping;
            r_last_pong  <= n_last_pong;
            r_ack_start  <= n_ack_start;
            r_clr_start  <= n_clr_start;
            r_loss_start <= n_loss_start;
        end
    end

endmodule
